>>> rtl/core/pmct_pkg.sv
// Shared constants and types for the PS/2 mouse packet cursor tracker.
package pmct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_IDX_BITS   = 2;
  localparam int BUTTON_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = CFG_IDX_BITS'(1);

  localparam int RESET_MAX_X = 79;
  localparam int RESET_MAX_Y = 24;
  localparam int RESET_POS_X = 40;
  localparam int RESET_POS_Y = 12;

  // Flag byte layout
  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;

  localparam int PKT_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                   sign_x;
    logic                   sign_y;
    logic [BUTTON_BITS-1:0] buttons;
    logic [7:0]             dx;
    logic [7:0]             dy;
  } pkt_t;

endpackage

>>> rtl/core/pmct_fifo.sv
// Small register-based FIFO; depth must be a power of two.
module pmct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fifo count did not grow on push");

endmodule

>>> rtl/core/pmct_front.sv
// Byte assembler: resyncs on the flag byte and emits whole three-byte packets.
module pmct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    rx_byte_i,
  output logic          pkt_push_o,
  output pmct_pkg::pkt_t pkt_o,
  input  logic          pkt_full_i
);

  import pmct_pkg::*;

  localparam logic [1:0] POS_FLAGS = 2'd0;
  localparam logic [1:0] POS_DX    = 2'd1;
  localparam logic [1:0] POS_DY    = 2'd2;

  logic [1:0] pos_q, pos_d;
  logic [7:0] flags_q, dx_q;
  logic       accept;

  // Only the closing byte needs room in the packet queue.
  assign full   = (pos_q == POS_DY) && pkt_full_i;
  assign accept = push && !full;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      case (pos_q)
        POS_FLAGS: pos_d = rx_byte_i[SYNC_BIT] ? POS_DX : POS_FLAGS;
        POS_DX:    pos_d = POS_DY;
        POS_DY:    pos_d = POS_FLAGS;
        default:   pos_d = POS_FLAGS;
      endcase
    end
  end

  assign pkt_push_o     = accept && (pos_q == POS_DY);
  assign pkt_o.sign_x   = flags_q[XSIGN_BIT];
  assign pkt_o.sign_y   = flags_q[YSIGN_BIT];
  assign pkt_o.buttons  = flags_q[BUTTON_BITS-1:0];
  assign pkt_o.dx       = dx_q;
  assign pkt_o.dy       = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FLAGS;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (pos_q == POS_FLAGS)) begin
      flags_q <= rx_byte_i;
    end
    if (accept && (pos_q == POS_DX)) begin
      dx_q <= rx_byte_i;
    end
  end

  a_resync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (pos_q == POS_FLAGS) && !rx_byte_i[SYNC_BIT]) |=> (pos_q == POS_FLAGS))
    else $error("unsynced flag byte was not dropped");

  a_pkt_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_push_o |=> (pos_q == POS_FLAGS) && $past(pos_q == POS_DY))
    else $error("packet closed outside the dy byte");

endmodule

>>> rtl/core/pmct_back.sv
// Cursor update: applies, clamps, queues a packet per cycle if queues allow.
module pmct_back #(
  parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pmct_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pmct_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  pmct_pkg::pkt_t                     pkt_i,
  input  logic                               pkt_empty_i,
  output logic                               pkt_pop_o,
  output logic                               out_push_o,
  output logic [2*COORD_BITS+pmct_pkg::BUTTON_BITS-1:0] out_data_o,
  input  logic                               out_full_i
);

  import pmct_pkg::*;

  localparam int XW = (COORD_BITS > CFG_DATA_BITS) ? COORD_BITS : CFG_DATA_BITS;
  localparam int SW = ((COORD_BITS > 9) ? COORD_BITS : 9) + 2;

  logic [COORD_BITS-1:0] max_x_q, max_y_q, pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [XW-1:0]         cfg_ext;
  logic signed [SW-1:0]  sum_x, sum_y, lim_x, lim_y;
  logic                  go;

  assign cfg_ext = XW'(cfg_data_i);

  assign go         = !pkt_empty_i && !out_full_i;
  assign pkt_pop_o  = go;
  assign out_push_o = go;

  // 9-bit deltas carry their sign from the flag byte
  assign sum_x = $signed({{(SW-COORD_BITS){1'b0}}, pos_x_q})
               + $signed({{(SW-9){pkt_i.sign_x}}, pkt_i.sign_x, pkt_i.dx});
  assign sum_y = $signed({{(SW-COORD_BITS){1'b0}}, pos_y_q})
               - $signed({{(SW-9){pkt_i.sign_y}}, pkt_i.sign_y, pkt_i.dy});
  assign lim_x = $signed({{(SW-COORD_BITS){1'b0}}, max_x_q});
  assign lim_y = $signed({{(SW-COORD_BITS){1'b0}}, max_y_q});

  always_comb begin
    if (sum_x[SW-1]) begin
      pos_x_d = '0;
    end else if (sum_x > lim_x) begin
      pos_x_d = max_x_q;
    end else begin
      pos_x_d = sum_x[COORD_BITS-1:0];
    end
    if (sum_y[SW-1]) begin
      pos_y_d = '0;
    end else if (sum_y > lim_y) begin
      pos_y_d = max_y_q;
    end else begin
      pos_y_d = sum_y[COORD_BITS-1:0];
    end
  end

  assign out_data_o = {pos_x_d, pos_y_d, pkt_i.buttons};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q <= COORD_BITS'(RESET_MAX_X);
      max_y_q <= COORD_BITS'(RESET_MAX_Y);
      pos_x_q <= COORD_BITS'(RESET_POS_X);
      pos_y_q <= COORD_BITS'(RESET_POS_Y);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_X: max_x_q <= cfg_ext[COORD_BITS-1:0];
          REG_MAX_Y: max_y_q <= cfg_ext[COORD_BITS-1:0];
          default:   ;
        endcase
      end
      if (go) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (pos_x_q <= $past(max_x_q)))
    else $error("cursor x beyond max");

  a_y_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (pos_y_q <= $past(max_y_q)))
    else $error("cursor y beyond max");

endmodule

>>> rtl/core/ps2_mouse_packet_cursor_tracker.sv
// Top level: byte assembler, packet queue, cursor update and result queue.
// Takes one byte per cycle while full is low; full rises only on a closing byte with
// the packet queue full. Each result passes the packet and result queues to the output.
// Throughput: one packet per cycle through the cursor update while both queues allow.
// Reset: cursor (40,12), maxima (79,24), byte counter at flag byte, both queues empty.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pmct_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pmct_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         rx_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [COORD_BITS-1:0]              cursor_x_o,
  output logic [COORD_BITS-1:0]              cursor_y_o,
  output logic [pmct_pkg::BUTTON_BITS-1:0]   button_bits_o
);

  import pmct_pkg::*;

  localparam int PW = $bits(pkt_t);
  localparam int RW = 2 * COORD_BITS + BUTTON_BITS;

  pkt_t          pkt_in, pkt_head;
  logic [PW-1:0] pkt_head_raw;
  logic          pkt_push, pkt_full, pkt_pop, pkt_empty;
  logic          res_push, res_full;
  logic [RW-1:0] res_in, res_out;

  pmct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .rx_byte_i  (rx_byte_i),
    .pkt_push_o (pkt_push),
    .pkt_o      (pkt_in),
    .pkt_full_i (pkt_full)
  );

  pmct_fifo #(
    .WIDTH (PW),
    .DEPTH (PKT_QUEUE_DEPTH)
  ) u_pkt_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .data_i  (pkt_in),
    .full_o  (pkt_full),
    .pop_i   (pkt_pop),
    .data_o  (pkt_head_raw),
    .empty_o (pkt_empty)
  );

  assign pkt_head = pkt_t'(pkt_head_raw);

  pmct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pkt_i       (pkt_head),
    .pkt_empty_i (pkt_empty),
    .pkt_pop_o   (pkt_pop),
    .out_push_o  (res_push),
    .out_data_o  (res_in),
    .out_full_i  (res_full)
  );

  pmct_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign cursor_x_o    = res_out[RW-1 -: COORD_BITS];
  assign cursor_y_o    = res_out[BUTTON_BITS +: COORD_BITS];
  assign button_bits_o = res_out[BUTTON_BITS-1:0];

endmodule

>>> tb/tb_ps2_mouse_packet_cursor_tracker.sv
// Self-checking testbench for the PS/2 mouse packet decoder and cursor tracker.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_cursor_tracker;
  import pmct_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);
  localparam int PHASE_BYTES = 385;

  typedef enum logic [1:0] {AT_FLAGS, AT_DX, AT_DY} pkt_slot_e;

  typedef struct packed {
    logic [CB-1:0]          x;
    logic [CB-1:0]          y;
    logic [BUTTON_BITS-1:0] btn;
  } cursor_rec_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [7:0]               rx_byte_i = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [CB-1:0]            cursor_x_o;
  logic [CB-1:0]            cursor_y_o;
  logic [BUTTON_BITS-1:0]   button_bits_o;

  // Tracker copy: packet assembly state, cursor and limits
  pkt_slot_e     slot;
  logic [7:0]    held_flags;
  logic [7:0]    held_dx;
  logic [CB-1:0] cur_x;
  logic [CB-1:0] cur_y;
  logic [CB-1:0] lim_x;
  logic [CB-1:0] lim_y;

  cursor_rec_t cursor_q[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  ps2_mouse_packet_cursor_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_bits_o (button_bits_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4ms;
    $display("ps2_mouse_packet_cursor_tracker test failed");
    $finish;
  end

  // Clamp of a signed sum into 0..limit
  function automatic logic [CB-1:0] clamp_to(input int v, input logic [CB-1:0] limit);
    if (v < 0) return '0;
    if (v > int'(limit)) return limit;
    return CB'(v);
  endfunction

  // Advance the tracker by one accepted byte; used is low when the byte is dropped
  task automatic track_byte(input logic [7:0] b, output bit used);
    int          dx;
    int          dy;
    cursor_rec_t r;
    used = 1'b1;
    case (slot)
      AT_FLAGS: begin
        if (!b[SYNC_BIT]) begin
          used = 1'b0;
        end else begin
          held_flags = b;
          slot = AT_DX;
        end
      end
      AT_DX: begin
        held_dx = b;
        slot = AT_DY;
      end
      default: begin
        slot = AT_FLAGS;
        dx = int'(held_dx) - (held_flags[XSIGN_BIT] ? 256 : 0);
        dy = int'(b) - (held_flags[YSIGN_BIT] ? 256 : 0);
        cur_x = clamp_to(int'(cur_x) + dx, lim_x);
        cur_y = clamp_to(int'(cur_y) - dy, lim_y);
        r.x = cur_x;
        r.y = cur_y;
        r.btn = held_flags[BUTTON_BITS-1:0];
        cursor_q.push_back(r);
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, output bit used);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    track_byte(b, used);
  endtask

  task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                             input logic [7:0] dy);
    bit used;
    send_byte(flags, used);
    send_byte(dx, used);
    send_byte(dy, used);
  endtask

  // Wait for all pending cursor updates, plus a margin for work still in flight
  task automatic drain_results();
    push <= 1'b0;
    while (cursor_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_X) lim_x = CB'(val);
    else if (idx == REG_MAX_Y) lim_y = CB'(val);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    cursor_rec_t want;
    if (rst_ni && !empty && pop) begin
      if (cursor_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result x=%0d y=%0d buttons=%0d", $realtime,
                   cursor_x_o, cursor_y_o, button_bits_o);
      end else begin
        want = cursor_q.pop_front();
        check_field("cursor_x", want.x, cursor_x_o);
        check_field("cursor_y", want.y, cursor_y_o);
        check_field("button_bits", want.btn, button_bits_o);
      end
    end
  end

  // Default limits: reset position, drops, sign extremes, clamps, ignored overflow bits
  task automatic test_default_packets();
    bit used;
    send_byte(8'h00, used);
    send_byte(8'hF7, used);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h0F, 8'h05, 8'h03);
    send_packet(8'hC9, 8'hFF, 8'h00);
    send_packet(8'h1A, 8'h00, 8'h00);
    send_packet(8'h08, 8'h00, 8'hFF);
    send_packet(8'h2C, 8'h00, 8'h00);
    send_packet(8'h3B, 8'h80, 8'hF0);
  endtask

  // Both registers, zero and full-scale limits, spare indexes, lowered limit
  task automatic test_limits();
    write_reg(REG_MAX_X, '0);
    write_reg(REG_MAX_Y, '0);
    send_packet(8'h08, 8'h10, 8'hF0);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 12'h123);
    send_packet(8'h28, 8'h40, 8'h01);
    write_reg(REG_MAX_X, '1);
    write_reg(REG_MAX_Y, '1);
    repeat (17) send_packet(8'h28, 8'hFF, 8'h01);
    // cursor now beyond the new limits; the next packet pulls it in
    write_reg(REG_MAX_X, 12'd100);
    write_reg(REG_MAX_Y, 12'd50);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h0D, 8'h00, 8'h00);
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct,
                             input logic [CFG_DATA_BITS-1:0] mx,
                             input logic [CFG_DATA_BITS-1:0] my);
    int   count;
    bit   used;
    logic [7:0] b;
    write_reg(REG_MAX_X, mx);
    write_reg(REG_MAX_Y, my);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    count = 0;
    while (count < PHASE_BYTES) begin
      if ($urandom_range(99) < 8) begin
        // noise byte, may break framing
        b = 8'($urandom_range(255));
      end else if (slot == AT_FLAGS) begin
        b = 8'($urandom_range(255)) | (8'h1 << SYNC_BIT);
      end else begin
        b = 8'($urandom_range(255));
      end
      send_byte(b, used);
      if (used) count++;
    end
  endtask

  initial begin
    slot = AT_FLAGS;
    held_flags = '0;
    held_dx = '0;
    cur_x = CB'(RESET_POS_X);
    cur_y = CB'(RESET_POS_Y);
    lim_x = CB'(RESET_MAX_X);
    lim_y = CB'(RESET_MAX_Y);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_packets();
    test_limits();
    test_random(0, 0, '1, '1);
    test_random(68, 0, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    test_random(0, 68, 12'($urandom_range(63)), 12'($urandom_range(63)));
    test_random(25, 25, 12'(RESET_MAX_X), 12'(RESET_MAX_Y));

    push <= 1'b0;
    recv_stall_pct = 0;
    for (int n = 0; n < 20000 && cursor_q.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (cursor_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("ps2_mouse_packet_cursor_tracker test passed");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pmct_pkg.sv
rtl/core/pmct_fifo.sv
rtl/core/pmct_front.sv
rtl/core/pmct_back.sv
rtl/core/ps2_mouse_packet_cursor_tracker.sv
tb/tb_ps2_mouse_packet_cursor_tracker.sv
